[src/sfe_pkg.sv]
// Shared types and constants for the stereo feedback echo block.
package sfe_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int AMOUNT_W    = 16;
  localparam int LENGTH_W    = 17;
  localparam int COEFF_W     = 16;
  localparam int GAIN_W      = 17;
  localparam int MAC_B_W     = 18;

  localparam logic [AMOUNT_W-1:0] BYPASS_LIMIT = 16'd655;
  localparam logic [GAIN_W-1:0]   FB_BASE      = 17'd13107;
  localparam logic [15:0]         FB_SLOPE     = 16'd19661;
  localparam logic [15:0]         WET_SLOPE    = 16'd20972;
  localparam logic [COEFF_W-1:0]  COEFF_RESET  = 16'd1887;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 17'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELAY_AMOUNT   = 2'd0,
    REG_DELAY_LENGTH   = 2'd1,
    REG_HIGHPASS_COEFF = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FB,
    ST_WET,
    ST_DIFF,
    ST_TRK,
    ST_UPD,
    ST_HP,
    ST_MFB,
    ST_MWET,
    ST_OUT,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic en;
    logic shift17;
  } mac_op_t;

endpackage

[src/stereo_feedback_echo_highpassed.sv]
// Echoed frame: the sequencer runs both channels through one shared multiplier,
// seven steps per channel, before the result is loaded into the output register.
// Bypassed frame (amount at or below 655): the input goes straight to the output register.
// A finished frame waits in the output register while the next frame is taken.
// After reset the echo memory is cleared one address per cycle, every address once,
// with in_ready low; configuration writes are taken throughout.
module stereo_feedback_echo_highpassed import sfe_pkg::*; #(
  parameter int MAX_DELAY   = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = $clog2(MAX_DELAY);
  localparam int LW = (PW + 1 > LENGTH_W) ? PW + 1 : LENGTH_W;
  localparam int TW = SB + 8;
  localparam int AW = SB + 9;
  localparam int MW = AW + 2;
  localparam int DW = 2 * SB;

  state_t state, state_next;

  logic [AMOUNT_W-1:0] amount;
  logic [LENGTH_W-1:0] length;
  logic [COEFF_W-1:0]  coeff;

  logic [PW-1:0] pos;
  logic [PW-1:0] clr_cnt;
  logic          ch;

  logic signed [SB-1:0] x_l, x_r, res_l, res_r, stored_l, stored_r;
  logic signed [TW-1:0] trk_l, trk_r;
  logic [GAIN_W-1:0]    fb, wet;
  logic signed [AW-1:0] diff, hp;

  logic [DW-1:0] rd_data;
  logic          mem_we;
  logic [PW-1:0] mem_addr;
  logic [DW-1:0] mem_wdata;

  mac_op_t              mac_op;
  logic signed [AW-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [MW-1:0] mac_out;

  logic signed [SB-1:0] word_sel, x_sel;
  logic signed [AW-1:0] echo_sel;
  logic signed [TW-1:0] trk_sel;
  logic signed [MW-1:0] trk_sum, smp_sum;
  logic                 bypass, out_free;

  logic [LW-1:0] pos_inc, len_raw, len_eff;
  logic [PW-1:0] pos_adv;

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [MW-1:0] v);
    if (&v[MW-1:SB-1] || ~|v[MW-1:SB-1]) begin
      return v[SB-1:0];
    end
    return v[MW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
  endfunction

  function automatic logic signed [TW-1:0] sat_track(input logic signed [MW-1:0] v);
    if (&v[MW-1:TW-1] || ~|v[MW-1:TW-1]) begin
      return v[TW-1:0];
    end
    return v[MW-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
  endfunction

  sfe_store #(
    .DEPTH  (MAX_DELAY),
    .DATA_W (DW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_data (mem_wdata),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  sfe_mac #(
    .A_W (AW)
  ) u_mac (
    .clk    (clk),
    .op     (mac_op),
    .a      (mac_a),
    .b      (mac_b),
    .result (mac_out)
  );

  assign cfg_ready = 1'b1;
  assign bypass    = (amount <= BYPASS_LIMIT);
  assign out_free  = !out_valid || out_ready;

  // Per-channel operand selection; the stored word is Q1.23, the echo is Q9.24.
  assign word_sel = ch ? rd_data[SB-1:0] : rd_data[DW-1:SB];
  assign echo_sel = {{(AW-SB-1){word_sel[SB-1]}}, word_sel, 1'b0};
  assign trk_sel  = ch ? trk_r : trk_l;
  assign x_sel    = ch ? x_r : x_l;
  assign trk_sum  = {{(MW-TW){trk_sel[TW-1]}}, trk_sel} + mac_out;
  assign smp_sum  = {{(MW-SB){x_sel[SB-1]}}, x_sel} + mac_out;

  // Position advance with the length clamped to one through MAX_DELAY.
  always_comb begin
    pos_inc = LW'(pos) + LW'(1);
    len_raw = LW'(length);
    if (len_raw == '0) begin
      len_eff = LW'(1);
    end else if (len_raw > LW'(MAX_DELAY)) begin
      len_eff = LW'(MAX_DELAY);
    end else begin
      len_eff = len_raw;
    end
    pos_adv = (pos_inc >= len_eff) ? '0 : pos_inc[PW-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == PW'(MAX_DELAY - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = bypass ? ST_DONE : ST_FB;
        end
      end
      ST_FB:   state_next = ST_WET;
      ST_WET:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_TRK;
      ST_TRK:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_HP;
      ST_HP:   state_next = ST_MFB;
      ST_MFB:  state_next = ST_MWET;
      ST_MWET: state_next = ST_OUT;
      ST_OUT:  state_next = ch ? ST_WB : ST_DIFF;
      ST_WB:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = pos;
    mem_wdata = {stored_l, stored_r};
    mac_op    = '0;
    mac_a     = '0;
    mac_b     = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_FB: begin
        mac_op = '{en: 1'b1, shift17: 1'b0};
        mac_a  = AW'(FB_SLOPE);
        mac_b  = MAC_B_W'(amount);
      end
      ST_WET: begin
        mac_op = '{en: 1'b1, shift17: 1'b0};
        mac_a  = AW'(WET_SLOPE);
        mac_b  = MAC_B_W'(amount);
      end
      ST_TRK: begin
        mac_op = '{en: 1'b1, shift17: 1'b0};
        mac_a  = diff;
        mac_b  = MAC_B_W'(coeff);
      end
      ST_MFB: begin
        mac_op = '{en: 1'b1, shift17: 1'b1};
        mac_a  = hp;
        mac_b  = MAC_B_W'(fb);
      end
      ST_MWET: begin
        mac_op = '{en: 1'b1, shift17: 1'b1};
        mac_a  = hp;
        mac_b  = MAC_B_W'(wet);
      end
      ST_WB: mem_we = 1'b1;
      default: begin
      end
    endcase
  end

  // Control state, configuration, position, output valid and filter trackers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pos       <= '0;
      ch        <= 1'b0;
      trk_l     <= '0;
      trk_r     <= '0;
      amount    <= '0;
      length    <= LENGTH_RESET;
      coeff     <= COEFF_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DELAY_AMOUNT:   amount <= cfg_data[AMOUNT_W-1:0];
          REG_DELAY_LENGTH:   length <= cfg_data[LENGTH_W-1:0];
          REG_HIGHPASS_COEFF: coeff  <= cfg_data[COEFF_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + PW'(1);
      end
      if (state == ST_IDLE) begin
        ch <= 1'b0;
      end
      if (state == ST_OUT) begin
        ch <= 1'b1;
      end
      if (state == ST_UPD) begin
        if (ch) begin
          trk_r <= sat_track(trk_sum);
        end else begin
          trk_l <= sat_track(trk_sum);
        end
      end
      if (state == ST_WB) begin
        pos <= pos_adv;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sample datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x_l   <= left_in;
        x_r   <= right_in;
        res_l <= left_in;
        res_r <= right_in;
      end
      ST_WET: fb <= FB_BASE + mac_out[GAIN_W-1:0];
      ST_DIFF: begin
        // On the second channel the unit holds the first channel's wet-scaled echo, not the wet gain.
        if (!ch) begin
          wet <= mac_out[GAIN_W-1:0];
        end
        diff <= echo_sel - {{(AW-TW){trk_sel[TW-1]}}, trk_sel};
      end
      ST_HP: hp <= echo_sel - {{(AW-TW){trk_sel[TW-1]}}, trk_sel};
      ST_MWET: begin
        if (ch) begin
          stored_r <= sat_sample(smp_sum);
        end else begin
          stored_l <= sat_sample(smp_sum);
        end
      end
      ST_OUT: begin
        if (ch) begin
          res_r <= sat_sample(smp_sum);
        end else begin
          res_l <= sat_sample(smp_sum);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          left_out  <= res_l;
          right_out <= res_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[src/sfe_mac.sv]
// Shared multiply unit with round-to-nearest right shift by 16 or 17 bits.
module sfe_mac import sfe_pkg::*; #(
  parameter int A_W = 33
) (
  input  logic                    clk,
  input  mac_op_t                 op,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [MAC_B_W-1:0] b,
  output logic signed [A_W+1:0]   result
);

  localparam int P_W = A_W + MAC_B_W;
  localparam logic signed [P_W-1:0] HALF16 = P_W'(32768);
  localparam logic signed [P_W-1:0] HALF17 = P_W'(65536);

  logic signed [P_W-1:0] mul;
  logic signed [P_W-1:0] prod;
  logic                  shift17_q;

  always_comb begin
    mul = a * b;
  end

  // The rounding offset is folded into the product so the consumer only adds.
  always_ff @(posedge clk) begin
    if (op.en) begin
      prod      <= mul + (op.shift17 ? HALF17 : HALF16);
      shift17_q <= op.shift17;
    end
  end

  assign result = shift17_q ? {prod[P_W-1], prod[P_W-1:17]} : prod[P_W-1:16];

endmodule

[src/sfe_store.sv]
// Single-port-write, registered-read memory for the stereo echo words.
module sfe_store #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 48,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/sfe_checker.sv]
// Port-level checks for the stereo feedback echo, bound to its top level.
module sfe_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] left_out,
  input logic signed [SAMPLE_BITS-1:0] right_out
);

  // A stalled output beat keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("output beat changed while stalled");

  // The block works on one frame at a time, so it drops ready after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a frame is in progress");

  // Reset starts the memory clearing pass, during which no frame is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready before the memory clearing pass");

endmodule

bind stereo_feedback_echo_highpassed sfe_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sfe_checker (.*);
